// ===== rtl/cdge_pkg.sv =====
// ----------------------------------------------------------------------------
// cdge_pkg
// Shared constants for the central-difference gradient edge block: register
// indexes, reset values, field widths and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package cdge_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned THR_REG_W    = 8;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [THR_REG_W-1:0]    THR_RESET    = 8'd10;

  // frame geometry
  localparam int unsigned DEFAULT_MAX_WIDTH = 1024;
  localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = 13'd4096;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned DIFF_W = 9;
  localparam int unsigned MAG_W  = 12;
  localparam int unsigned SUMSQ_W = 18;
  localparam int unsigned RAD_W  = 24;  // 64 * sum of squares

  // result word: row, col, diff_x, diff_y, magnitude, edge_res, zero fill
  localparam int unsigned RES_BITS = ROW_W + COL_W + 2 * DIFF_W + MAG_W + 1;
  localparam int unsigned OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int unsigned IN_TDATA_W  = 8;

endpackage : cdge_pkg

`default_nettype wire

// ===== rtl/central_difference_gradient_edge.sv =====
// ----------------------------------------------------------------------------
// central_difference_gradient_edge
// Streaming central-difference gradient with magnitude and edge threshold.
// Two line stores in block memory hold the previous rows; each pixel is
// turned into up to three results, each sent through a shared iterative
// square-root unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: row, col, diff_x,
//                                                diff_y, magnitude, edge_res;
//                                                tlast = last of frame
//  cfg       in   cfg_we_i (no wait)             cfg_idx_i, cfg_data_i
//
//  A pixel goes through line-store access (read, read, read, write back),
//  then, for each result it causes: select, square, 12 root steps, hand
//  over. The single iterative root unit is shared by all results, and a new
//  pixel is taken only once its last result, if any, has been handed over.
//  Reset clears the counters and loads the register defaults; the line
//  stores are not cleared. The input is held off until a run flag, cleared
//  by reset, is set by the clock. A stalled result holds the output register,
//  and the next pixel is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module central_difference_gradient_edge #(
  parameter int unsigned MAX_WIDTH = cdge_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // [7:0] pixel
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [cdge_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [11:0] out_row, [21:12] out_col, [30:22] diff_x, [39:31] diff_y,
  // [51:40] magnitude, [52] edge_res, upper bits zero
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [cdge_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_we_i,
  input  wire logic [cdge_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cdge_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import cdge_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam logic [HEIGHT_REG_W-1:0] MaxW = HEIGHT_REG_W'(MAX_WIDTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_RD2  = 3'd2;
  localparam logic [2:0] ST_RD3  = 3'd3;
  localparam logic [2:0] ST_SEL  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_SQRT = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // configuration
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [THR_REG_W-1:0]    thr_q;
  logic [2*THR_REG_W-1:0]  thr_sq_q;

  // control
  logic [2:0]    state_q, state_d;
  logic          run_q;
  logic [AW-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [2:0]    pend_q, pend_d;
  logic [3:0]    iter_q;

  // item and result payload
  logic [AW-1:0]    item_c_q;
  logic [ROW_W-1:0] item_r_q;
  logic [PIX_W-1:0] pix_q;
  logic             item_last_col_q, item_last_row_q;
  logic [PIX_W-1:0] lc_c_q, la_c_q, lc_n_q, la_p_q;
  logic [ROW_W-1:0] res_row_q;
  logic [COL_W-1:0] res_col_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic             res_last_q, edge_q;
  logic [RAD_W-1:0] rad_q;
  logic [MAG_W:0]   rem_q;
  logic [MAG_W-1:0] root_q;

  // output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   m_last_q;

  // line stores
  logic [PIX_W-1:0] lc_mem [MAX_WIDTH];
  logic [PIX_W-1:0] la_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lc_rd_q, la_rd_q;
  logic [AW-1:0]    lc_raddr, la_raddr;
  logic             rd_en, wr_en;

  logic in_fire, out_load;
  logic [HEIGHT_REG_W-1:0] w_eff, wm1, h_eff, hm1;
  logic last_col, last_row;

  // ---------------------------------------------------------------- geometry
  always_comb begin
    if (width_q == '0) begin
      w_eff = HEIGHT_REG_W'(1);
    end else if (HEIGHT_REG_W'(width_q) > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = HEIGHT_REG_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (height_q > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = height_q;
    end
    wm1 = w_eff - HEIGHT_REG_W'(1);
    hm1 = h_eff - HEIGHT_REG_W'(1);
  end

  assign last_col = HEIGHT_REG_W'(col_q) >= wm1;
  assign last_row = HEIGHT_REG_W'(row_q) >= hm1;

  assign s_axis_tready = run_q && (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // ------------------------------------------------------------ line stores
  always_comb begin
    lc_raddr = col_q;
    la_raddr = col_q;
    rd_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_en = in_fire;
      end
      ST_RD1: begin
        lc_raddr = item_c_q + AW'(1);
        la_raddr = item_c_q - AW'(1);
        rd_en    = 1'b1;
      end
      ST_RD2: begin
        lc_raddr = item_c_q - AW'(2);
        la_raddr = item_c_q;
        rd_en    = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = (state_q == ST_RD3);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      lc_rd_q <= lc_mem[lc_raddr];
    end
    if (wr_en) begin
      lc_mem[item_c_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en && (state_q != ST_RD2)) begin
      la_rd_q <= la_mem[la_raddr];
    end
    if (wr_en) begin
      la_mem[item_c_q] <= lc_c_q;
    end
  end

  // ---------------------------------------------------------- result select
  logic signed [DIFF_W-1:0] dx_d, dy_d;
  logic [ROW_W-1:0] row_d;
  logic [AW-1:0]    col_d;
  logic             last_d;
  logic             dx1_en, dy1_en, dx2_en;

  assign dx1_en = (item_c_q != '0) && !item_last_col_q;
  assign dy1_en = item_r_q >= ROW_W'(2);
  assign dx2_en = (item_c_q >= AW'(2)) &&
                  (HEIGHT_REG_W'(item_c_q - AW'(1)) < wm1);

  always_comb begin
    dx_d   = '0;
    dy_d   = '0;
    row_d  = item_r_q;
    col_d  = item_c_q;
    last_d = 1'b0;
    if (pend_q[0]) begin
      // result for the pixel in the row above
      row_d = item_r_q - ROW_W'(1);
      if (dx1_en) begin
        dx_d = $signed({1'b0, lc_n_q} - {1'b0, la_p_q});
      end
      if (dy1_en) begin
        dy_d = $signed({1'b0, pix_q} - {1'b0, la_c_q});
      end
    end else if (pend_q[1]) begin
      // last row: pixel one column back
      col_d = item_c_q - AW'(1);
      if (dx2_en) begin
        dx_d = $signed({1'b0, pix_q} - {1'b0, lc_rd_q});
      end
    end else begin
      last_d = 1'b1;
    end
  end

  // ------------------------------------------------------- squares and root
  logic signed [SUMSQ_W-1:0] sq_x, sq_y;
  logic [SUMSQ_W-1:0] sum_sq;
  logic [MAG_W+2:0]   rem_sh;
  logic [MAG_W+2:0]   trial;

  assign sq_x   = dx_q * dx_q;
  assign sq_y   = dy_q * dy_q;
  assign sum_sq = $unsigned(sq_x) + $unsigned(sq_y);

  assign rem_sh = {rem_q[MAG_W:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = (MAG_W+3)'({root_q, 2'b01});

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        state_d = ST_RD2;
      end
      ST_RD2: begin
        state_d = ST_RD3;
      end
      ST_RD3: begin
        pend_d = {item_last_row_q && item_last_col_q,
                  item_last_row_q && (item_c_q != '0),
                  item_r_q != '0};
        state_d = (pend_d != '0) ? ST_SEL : ST_IDLE;
      end
      ST_SEL: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (iter_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          // drop the lowest pending result
          pend_d  = pend_q & (pend_q - 3'd1);
          state_d = (pend_d != '0) ? ST_SEL : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      run_q     <= 1'b0;
      pend_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      iter_q    <= '0;
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      thr_q     <= THR_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= 1'b1;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:    width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT:   height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
          REG_EDGE_THRESHOLD: thr_q    <= cfg_data_i[THR_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + AW'(1);
        end
      end
      if (state_q == ST_MUL) begin
        iter_q <= 4'(MAG_W - 1);
      end else if (state_q == ST_SQRT) begin
        iter_q <= iter_q - 4'd1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
    if (in_fire) begin
      item_c_q        <= col_q;
      item_r_q        <= row_q;
      pix_q           <= s_axis_tdata[PIX_W-1:0];
      item_last_col_q <= last_col;
      item_last_row_q <= last_row;
    end
    if (state_q == ST_RD1) begin
      lc_c_q <= lc_rd_q;
      la_c_q <= la_rd_q;
    end
    if (state_q == ST_RD2) begin
      lc_n_q <= lc_rd_q;
      la_p_q <= la_rd_q;
    end
    if (state_q == ST_SEL) begin
      dx_q       <= dx_d;
      dy_q       <= dy_d;
      res_row_q  <= row_d;
      res_col_q  <= COL_W'(col_d);
      res_last_q <= last_d;
    end
    if (state_q == ST_MUL) begin
      edge_q <= sum_sq > {thr_sq_q, 2'b00};
      rad_q  <= {sum_sq, 6'b000000};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == ST_SQRT) begin
      // one result bit a step
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= (MAG_W+1)'(rem_sh - trial);
        root_q <= {root_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q  <= (MAG_W+1)'(rem_sh);
        root_q <= {root_q[MAG_W-2:0], 1'b0};
      end
    end
    if (out_load) begin
      m_data_q <= OUT_TDATA_W'({edge_q, root_q, dy_q, dx_q, res_col_q, res_row_q});
      m_last_q <= res_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule : central_difference_gradient_edge

`default_nettype wire

// ===== test/central_difference_gradient_edge_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// central_difference_gradient_edge_tb
// Streams gray frames of many shapes through the gradient edge block and
// checks every result word against an in-bench prediction of the central
// differences, the 1/8-unit magnitude, the edge flag and the frame end.
// ----------------------------------------------------------------------------
module central_difference_gradient_edge_tb;
  import cdge_pkg::*;

  localparam int unsigned LINE_DEPTH    = DEFAULT_MAX_WIDTH;
  localparam int unsigned DRAIN_CYCLES  = 64;   // longer than the worst-case pixel
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned RANDOM_PIXELS = 150;
  localparam int unsigned WIDE_LEAD     = 29;
  localparam int unsigned TALL_LEAD     = 19;
  localparam longint unsigned CYCLE_LIMIT = 2_500_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int unsigned COL_LSB  = ROW_W;
  localparam int unsigned DX_LSB   = COL_LSB + COL_W;
  localparam int unsigned DY_LSB   = DX_LSB + DIFF_W;
  localparam int unsigned MAG_LSB  = DY_LSB + DIFF_W;
  localparam int unsigned EDGE_BIT = MAG_LSB + MAG_W;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIFF_W-1:0] diff_x;
    logic [DIFF_W-1:0] diff_y;
    logic [MAG_W-1:0]  magnitude;
    logic              edge_flag;
    logic              frame_end;
  } grad_result_t;

  typedef enum logic {PAT_RANDOM, PAT_QUADRANTS} pix_pattern_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // gradient predictor state
  logic [PIX_W-1:0]        line_prev [LINE_DEPTH];
  logic [PIX_W-1:0]        line_last [LINE_DEPTH];
  int unsigned             row_pos = 0;
  int unsigned             col_pos = 0;
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  logic [THR_REG_W-1:0]    thr_reg    = THR_RESET;

  grad_result_t    expected_grads[$];
  int unsigned     mismatches     = 0;
  bit              sender_idles   = 1'b1;
  bit              receiver_idles = 1'b1;
  bit              hold_request   = 1'b0;
  longint unsigned cycle_count    = 0;

  central_difference_gradient_edge dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // row, col, diff_x, diff_y, magnitude, edge_res
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned frame_cols();
    int unsigned w = width_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned r = 0;
    int unsigned trial;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = r | (1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic void queue_gradient(int unsigned row, int unsigned col,
                                         int dx, int dy, bit at_end);
    grad_result_t g;
    int unsigned  sumsq;
    sumsq       = dx * dx + dy * dy;
    g.row       = row[ROW_W-1:0];
    g.col       = col[COL_W-1:0];
    g.diff_x    = dx[DIFF_W-1:0];
    g.diff_y    = dy[DIFF_W-1:0];
    g.magnitude = MAG_W'(floor_root(64 * sumsq));
    g.edge_flag = sumsq > 4 * thr_reg * thr_reg;
    g.frame_end = at_end;
    expected_grads.push_back(g);
  endfunction

  // Work out the results caused by one accepted pixel and advance the raster.
  function automatic void predict_gradients(logic [PIX_W-1:0] pix);
    int unsigned w, h, r, c;
    int          p, dx, dy;
    bit          at_last_col, at_last_row;
    w = frame_cols();
    h = frame_rows();
    r = row_pos;
    c = col_pos;
    p = int'(pix);
    at_last_col = c >= w - 1;
    at_last_row = r >= h - 1;
    if (r >= 1) begin
      dx = 0;
      dy = 0;
      if (c >= 1 && !at_last_col) dx = int'(line_last[c + 1]) - int'(line_prev[c - 1]);
      if (r >= 2) dy = p - int'(line_prev[c]);
      queue_gradient(r - 1, c, dx, dy, 1'b0);
    end
    if (at_last_row && c >= 1) begin
      dx = 0;
      if (c >= 2 && c - 1 < w - 1) dx = p - int'(line_last[c - 2]);
      queue_gradient(r, c - 1, dx, 0, 1'b0);
    end
    if (at_last_row && at_last_col) queue_gradient(r, c, 0, 0, 1'b1);
    line_prev[c] = line_last[c];
    line_last[c] = pix;
    if (at_last_col) begin
      col_pos = 0;
      row_pos = at_last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void log_mismatch(string what, grad_result_t want, grad_result_t seen);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t %s: expected row %0d col %0d dx %0d dy %0d mag %0d edge %0b last %0b",
               $realtime, what, want.row, want.col, $signed(want.diff_x),
               $signed(want.diff_y), want.magnitude, want.edge_flag, want.frame_end);
      $display("      actual   row %0d col %0d dx %0d dy %0d mag %0d edge %0b last %0b",
               seen.row, seen.col, $signed(seen.diff_x), $signed(seen.diff_y),
               seen.magnitude, seen.edge_flag, seen.frame_end);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    grad_result_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.row       = m_axis_tdata[0 +: ROW_W];
      seen.col       = m_axis_tdata[COL_LSB +: COL_W];
      seen.diff_x    = m_axis_tdata[DX_LSB +: DIFF_W];
      seen.diff_y    = m_axis_tdata[DY_LSB +: DIFF_W];
      seen.magnitude = m_axis_tdata[MAG_LSB +: MAG_W];
      seen.edge_flag = m_axis_tdata[EDGE_BIT];
      seen.frame_end = m_axis_tlast;
      if (expected_grads.size() == 0) begin
        log_mismatch("unexpected result", '0, seen);
      end else begin
        want = expected_grads.pop_front();
        if (seen !== want || m_axis_tdata[OUT_TDATA_W-1:RES_BITS] !== '0)
          log_mismatch("result mismatch", want, seen);
      end
    end
  end

  // Result side: random stalls per transfer, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned pause;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pause = receiver_idles ? $urandom_range(0, 5) : 0;
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !hold_request);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    width_reg  = value[WIDTH_REG_W-1:0];
      REG_IMAGE_HEIGHT:   height_reg = value[HEIGHT_REG_W-1:0];
      REG_EDGE_THRESHOLD: thr_reg    = value[THR_REG_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Leaves tvalid high after the transfer; stop_pixels, or a gap in the next call, drops it.
  task automatic send_pixel(logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_gradients(pix);
  endtask

  task automatic stop_pixels();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_grads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] pixel_at(pix_pattern_e pattern, int unsigned r,
                                                int unsigned c);
    if (pattern == PAT_QUADRANTS) return ((r >= 2) ^ (c >= 2)) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(pix_pattern_e pattern);
    int unsigned cols, rows;
    cols = frame_cols();
    rows = frame_rows();
    for (int unsigned r = 0; r < rows; r++)
      for (int unsigned c = 0; c < cols; c++)
        send_pixel(pixel_at(pattern, r, c));
    stop_pixels();
  endtask

  // Full-scale steps in both directions; threshold stays at its reset value.
  task automatic test_extreme_quadrants();
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 4);
    send_frame(PAT_QUADRANTS);
    wait_idle();
  endtask

  task automatic test_degenerate_geometry();
    write_reg(REG_EDGE_THRESHOLD, 0);
    // zero width and height count as one
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_frame(PAT_RANDOM);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_frame(PAT_RANDOM);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 1);
    // an unmapped index must leave the geometry alone
    write_reg(REG_UNMAPPED, 13'h1FFF);
    send_frame(PAT_RANDOM);
    wait_idle();
  endtask

  // A difference of exactly twice the threshold is no edge; one level more is.
  task automatic test_edge_boundary();
    write_reg(REG_IMAGE_WIDTH, 13'h1803);   // upper bits dropped, width 3
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_EDGE_THRESHOLD, 20);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd40);
    stop_pixels();
    wait_idle();
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd41);
    stop_pixels();
    wait_idle();
  endtask

  // Run the start of a row at saturated width, then close it at a narrower
  // width set between transfers.
  task automatic test_widest_rows();
    write_reg(REG_IMAGE_WIDTH, 13'h07FF);   // saturates to the line store depth
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_EDGE_THRESHOLD, 255);
    for (int unsigned c = 0; c < WIDE_LEAD; c++)
      send_pixel(pixel_at(PAT_RANDOM, 0, c));
    stop_pixels();
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(WIDE_LEAD + 1));
    send_pixel(pixel_at(PAT_RANDOM, 0, WIDE_LEAD));
    stop_pixels();
    wait_idle();
  endtask

  // Same idea down a single column at saturated height.
  task automatic test_tallest_column();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);  // saturates to 4096 rows
    write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
    for (int unsigned r = 0; r < TALL_LEAD; r++)
      send_pixel(pixel_at(PAT_RANDOM, r, 0));
    stop_pixels();
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(TALL_LEAD + 1));
    send_pixel(pixel_at(PAT_RANDOM, TALL_LEAD, 0));
    stop_pixels();
    wait_idle();
  endtask

  // Hold the output off long enough for the block to back up into its input.
  task automatic test_stalled_output();
    write_reg(REG_IMAGE_WIDTH, 6);
    write_reg(REG_IMAGE_HEIGHT, 4);
    write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
    sender_idles = 1'b0;
    hold_request = 1'b1;
    send_frame(PAT_RANDOM);
    wait_idle();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned sent = 0;
    while (sent < RANDOM_PIXELS) begin
      sender_idles   = $urandom_range(0, 3) != 0;
      receiver_idles = $urandom_range(0, 3) != 0;
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
      case ($urandom_range(0, 3))
        0:       write_reg(REG_EDGE_THRESHOLD, 0);
        1:       write_reg(REG_EDGE_THRESHOLD, 255);
        default: write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
      endcase
      send_frame(PAT_RANDOM);
      sent += frame_cols() * frame_rows();
      wait_idle();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_quadrants();
    test_degenerate_geometry();
    test_edge_boundary();
    test_stalled_output();
    test_widest_rows();
    test_tallest_column();
    test_random_frames();
    wait_idle();
    if (mismatches == 0 && expected_grads.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
